FILE: rtl/chained_hash_map_assert.svh
// assertion macros shared by the hash map rtl
`ifndef CHAINED_HASH_MAP_ASSERT_SVH
`define CHAINED_HASH_MAP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CHM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash map check failed");

// next-cycle implication, disabled during reset
`define CHM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash map check failed");

`endif

FILE: rtl/chm_pkg.sv
// shared constants for the chained hash map
`default_nettype none

package chm_pkg;

  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // request action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/chm_if.sv
// request and response channel interfaces of the hash map
`default_nettype none

interface chm_req_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [chm_pkg::KEY_W-1:0]   key;
  logic signed [chm_pkg::VALUE_W-1:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

interface chm_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [chm_pkg::STATUS_W-1:0]        status;
  logic signed [chm_pkg::VALUE_W-1:0]  read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/chained_hash_map.sv
// top level of the separate-chaining hash map with a fixed entry pool
//
//  channel  dir  handshake       payload
//  req      in   valid / ready   action, key, value
//  rsp      out  valid / ready   status, read_value
//
// one request at a time, in the steps accept (S_IDLE), remainder (S_HASH),
// head read (S_HEAD_RD, S_HEAD), a walk step (S_WALK) per chain entry visited,
// update (S_WRITE, then S_LINK when appending behind an existing entry) and
// result (S_DONE); the remainder unit and the single pool memory port set the pace.
// after reset the bucket heads are cleared, with req.ready low.
// a held result stalls the next request only at its result step (S_DONE).
`default_nettype none

`include "chained_hash_map_assert.svh"

module chained_hash_map #(
  parameter int BUCKET_COUNT = 16,
  parameter int POOL_ENTRIES = 256
) (
  input wire logic   clk,
  input wire logic   rst,
  chm_req_if.sink    req,
  chm_rsp_if.source  rsp
);

  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_HASH    = 4'd2;
  localparam logic [3:0] S_HEAD_RD = 4'd3;
  localparam logic [3:0] S_HEAD    = 4'd4;
  localparam logic [3:0] S_WALK    = 4'd5;
  localparam logic [3:0] S_WRITE   = 4'd6;
  localparam logic [3:0] S_LINK    = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  typedef struct packed {
    logic signed [chm_pkg::KEY_W-1:0]   key;
    logic signed [chm_pkg::VALUE_W-1:0] value;
    logic [LW-1:0]                      next;
  } entry_t;

  logic [3:0]    state;
  logic [BW-1:0] clr_idx;

  // request registers
  logic                               act;
  logic signed [chm_pkg::KEY_W-1:0]   key_q;
  logic signed [chm_pkg::VALUE_W-1:0] val_q;
  logic [BW-1:0]                      bucket_q;

  // walk registers
  logic [LW-1:0] cur;
  logic [LW-1:0] prev;
  entry_t        prev_ent;
  entry_t        hit_ent;
  logic          hit;
  logic [LW-1:0] count;

  // result registers
  logic [chm_pkg::STATUS_W-1:0]       res_status;
  logic signed [chm_pkg::VALUE_W-1:0] res_value;
  logic                               out_valid;
  logic [chm_pkg::STATUS_W-1:0]       out_status;
  logic signed [chm_pkg::VALUE_W-1:0] out_value;

  // memories and their ports
  logic [LW-1:0] head_mem [BUCKET_COUNT];
  logic [LW-1:0] head_rd;
  logic          head_we;
  logic [BW-1:0] head_wa;
  logic [LW-1:0] head_wd;

  entry_t        pool_mem [POOL_ENTRIES];
  entry_t        pool_rd;
  logic [PW-1:0] pool_ra;
  logic          pool_we;
  logic [PW-1:0] pool_wa;
  entry_t        pool_wd;

  logic          rem_start;
  logic          rem_done;
  logic [BW-1:0] rem_bucket;

  logic req_fire;
  logic rsp_free;

  assign req.ready  = (state == S_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign rsp_free   = !out_valid || rsp.ready;
  assign rem_start  = req_fire;

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.read_value = out_value;

  chm_rem #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_rem (
    .clk    (clk),
    .rst    (rst),
    .start  (rem_start),
    .key    (req.key),
    .done   (rem_done),
    .bucket (rem_bucket)
  );

  // bucket head memory, registered read at the latched bucket
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd <= head_mem[bucket_q];
  end

  // entry pool memory, registered read
  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_wa] <= pool_wd;
    end
    pool_rd <= pool_mem[pool_ra];
  end

  // memory port selection
  always_comb begin
    head_we = 1'b0;
    head_wa = bucket_q;
    head_wd = count;
    pool_ra = cur[PW-1:0];
    pool_we = 1'b0;
    pool_wa = count[PW-1:0];
    pool_wd = '{key: key_q, value: val_q, next: NULL_LINK};
    case (state)
      S_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_idx;
        head_wd = NULL_LINK;
      end
      S_HEAD: begin
        pool_ra = head_rd[PW-1:0];
      end
      S_WALK: begin
        pool_ra = pool_rd.next[PW-1:0];
      end
      S_WRITE: begin
        if (act == chm_pkg::ACT_INSERT) begin
          if (hit) begin
            pool_we = 1'b1;
            pool_wa = cur[PW-1:0];
            pool_wd = '{key: hit_ent.key, value: val_q, next: hit_ent.next};
          end else if (count < NULL_LINK) begin
            pool_we = 1'b1;
            head_we = (prev == NULL_LINK);
          end
        end
      end
      S_LINK: begin
        pool_we = 1'b1;
        pool_wa = prev[PW-1:0];
        pool_wd = '{key: prev_ent.key, value: prev_ent.value, next: count};
      end
      default: begin
      end
    endcase
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // result register loads at the result cycle and clears once taken
      if ((state == S_DONE) && rsp_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + BW'(1);
          if (clr_idx == BW'(BUCKET_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (rem_done) begin
            state <= S_HEAD_RD;
          end
        end
        S_HEAD_RD: begin
          state <= S_HEAD;
        end
        S_HEAD: begin
          state <= (head_rd < count) ? S_WALK : S_WRITE;
        end
        S_WALK: begin
          if ((pool_rd.key == key_q) || (pool_rd.next >= count)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if ((act == chm_pkg::ACT_INSERT) && !hit && (count < NULL_LINK)) begin
            if (prev == NULL_LINK) begin
              count <= count + LW'(1);
              state <= S_DONE;
            end else begin
              state <= S_LINK;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_LINK: begin
          count <= count + LW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request, walk and result datapath
  always_ff @(posedge clk) begin
    if (req_fire) begin
      act   <= req.action;
      key_q <= req.key;
      val_q <= req.value;
      hit   <= 1'b0;
    end
    if ((state == S_HASH) && rem_done) begin
      bucket_q <= rem_bucket;
    end
    if (state == S_HEAD) begin
      cur  <= head_rd;
      prev <= NULL_LINK;
    end
    if (state == S_WALK) begin
      if (pool_rd.key == key_q) begin
        hit     <= 1'b1;
        hit_ent <= pool_rd;
      end else begin
        prev     <= cur;
        prev_ent <= pool_rd;
        cur      <= pool_rd.next;
      end
    end
    if (state == S_WRITE) begin
      if (act == chm_pkg::ACT_LOOKUP) begin
        if (hit) begin
          res_status <= chm_pkg::ST_HIT;
          res_value  <= hit_ent.value;
        end else begin
          res_status <= chm_pkg::ST_MISS;
          res_value  <= '0;
        end
      end else begin
        res_value <= '0;
        if (hit) begin
          res_status <= chm_pkg::ST_HIT;
        end else if (count >= NULL_LINK) begin
          res_status <= chm_pkg::ST_FULL;
        end else begin
          res_status <= chm_pkg::ST_NEW;
        end
      end
    end
    if ((state == S_DONE) && rsp_free) begin
      out_status <= res_status;
      out_value  <= res_value;
    end
  end

  // checks on the sequencer and pool bookkeeping
  `CHM_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= NULL_LINK)
  `CHM_ASSERT_IMP(a_walk_written, clk, rst, state == S_WALK, cur < count)
  `CHM_ASSERT_NXT(a_link_grows, clk, rst, state == S_LINK, count == $past(count) + LW'(1))
  `CHM_ASSERT_IMP(a_full_only_when_full, clk, rst,
    (state == S_DONE) && (res_status == chm_pkg::ST_FULL), count == NULL_LINK)

endmodule

`default_nettype wire

FILE: rtl/chm_rem.sv
// digit-serial non-negative remainder of a signed key by the bucket count
`default_nettype none

module chm_rem #(
  parameter int BUCKET_COUNT = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [chm_pkg::KEY_W-1:0]  key,
  output logic                                   done,
  output logic [((BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1)-1:0] bucket
);

  localparam int BW    = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int DIGIT = 4;
  localparam int STEPS = chm_pkg::KEY_W / DIGIT;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [BW:0] DIV = (BW+1)'(BUCKET_COUNT);

  logic [chm_pkg::KEY_W-1:0] mag;
  logic [BW-1:0]             rem;
  logic [BW-1:0]             rem_next;
  logic                      neg;
  logic                      busy;
  logic [CW-1:0]             cnt;

  // one digit of long division: four shift and conditional subtract steps
  always_comb begin
    logic [BW:0]   s;
    logic [BW-1:0] t;
    t = rem;
    for (int i = 0; i < DIGIT; i++) begin
      s = {t, mag[chm_pkg::KEY_W-1-i]};
      if (s >= DIV) begin
        s = s - DIV;
      end
      t = s[BW-1:0];
    end
    rem_next = t;
  end

  // sequencing of the digit steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        done <= 1'b0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  // datapath: magnitude shifts out msb first, remainder accumulates
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= key[chm_pkg::KEY_W-1];
      mag <= key[chm_pkg::KEY_W-1] ? (~key + 1'b1) : key;
      rem <= '0;
    end else if (busy) begin
      mag <= mag << DIGIT;
      rem <= rem_next;
    end
  end

  // a negative key folds its remainder back into range
  assign bucket = (neg && (rem != '0)) ? BW'(DIV - {1'b0, rem}) : rem;

endmodule

`default_nettype wire
